// ===== sv/ndo_pkg.sv =====
// ----------------------------------------------------------------------------
// ndo_pkg
// Shared types, register map and microcode for the disturbance observer.
// ----------------------------------------------------------------------------
package ndo_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int UCODE_LEN = 10;
   localparam int STEP_W    = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN     = 3'd0,
      CSR_INV_MASS = 3'd1,
      CSR_DAMPING  = 3'd2,
      CSR_STIFF    = 3'd3,
      CSR_FRICTION = 3'd4,
      CSR_TIME     = 3'd5
   } csr_type;

   typedef struct packed {
      logic        [30:0] observer_gain;
      logic        [30:0] inverse_mass;
      logic signed [31:0] damping;
      logic signed [31:0] stiffness;
      logic signed [31:0] friction_coeff;
      logic        [16:0] time_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      observer_gain:  31'd3276800,
      inverse_mass:   31'd65536,
      damping:        32'sd131072,
      stiffness:      32'sd1310720,
      friction_coeff: 32'sd6554,
      time_step:      17'd66
   };

   // multiplier operand sources
   typedef enum logic [3:0] {
      OPD_X     = 4'd0,
      OPD_V     = 4'd1,
      OPD_U     = 4'd2,
      OPD_GAIN  = 4'd3,
      OPD_INVM  = 4'd4,
      OPD_DAMP  = 4'd5,
      OPD_STIFF = 4'd6,
      OPD_FRIC  = 4'd7,
      OPD_DT    = 4'd8,
      OPD_W     = 4'd9,
      OPD_NUM   = 4'd10,
      OPD_F     = 4'd11,
      OPD_D     = 4'd12,
      OPD_DZ    = 4'd13
   } opnd_type;

   typedef enum logic [1:0] {
      ALU_MOV = 2'd0,
      ALU_ADD = 2'd1,
      ALU_SUB = 2'd2,
      ALU_NEG = 2'd3
   } alu_type;

   typedef enum logic [1:0] {
      SRC_U   = 2'd0,
      SRC_NUM = 2'd1,
      SRC_Z   = 2'd2,
      SRC_NEG = 2'd3
   } src_type;

   typedef enum logic [2:0] {
      DST_W   = 3'd0,
      DST_NUM = 3'd1,
      DST_F   = 3'd2,
      DST_D   = 3'd3,
      DST_DZ  = 3'd4,
      DST_Z   = 3'd5,
      DST_NEG = 3'd6
   } dst_type;

   typedef enum logic [1:0] {
      NX_NEXT        = 2'd0,
      NX_DONE        = 2'd1,
      NX_DONE_IF_DT0 = 2'd2
   } nxt_type;

   typedef struct packed {
      opnd_type a_sel;
      opnd_type b_sel;
      alu_type  alu_op;
      src_type  src;
      dst_type  dst;
      nxt_type  nxt;
   } ucode_type;

   typedef enum logic [6:0] {
      PH_IDLE = 7'b0000001,
      PH_LOAD = 7'b0000010,
      PH_LO   = 7'b0000100,
      PH_HI   = 7'b0001000,
      PH_POST = 7'b0010000,
      PH_ALU  = 7'b0100000,
      PH_DONE = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic     start;
      logic     load;
      logic     lo;
      logic     hi;
      logic     post;
      logic     alu;
      opnd_type a_sel;
      opnd_type b_sel;
      alu_type  alu_op;
      src_type  src;
      dst_type  dst;
   } ctl_type;

   // w = v*v, w = w*v, num = u - c*v - k*x - b*w, f = num*invm,
   // d = z + L*v, neg = -L*d, dz = neg - L*f, z = z + dz*dt
   localparam ucode_type UCODE [UCODE_LEN] = '{
      '{a_sel: OPD_V,     b_sel: OPD_V,    alu_op: ALU_MOV, src: SRC_U,
        dst: DST_W,   nxt: NX_NEXT},
      '{a_sel: OPD_W,     b_sel: OPD_V,    alu_op: ALU_MOV, src: SRC_U,
        dst: DST_W,   nxt: NX_NEXT},
      '{a_sel: OPD_DAMP,  b_sel: OPD_V,    alu_op: ALU_SUB, src: SRC_U,
        dst: DST_NUM, nxt: NX_NEXT},
      '{a_sel: OPD_STIFF, b_sel: OPD_X,    alu_op: ALU_SUB, src: SRC_NUM,
        dst: DST_NUM, nxt: NX_NEXT},
      '{a_sel: OPD_FRIC,  b_sel: OPD_W,    alu_op: ALU_SUB, src: SRC_NUM,
        dst: DST_NUM, nxt: NX_NEXT},
      '{a_sel: OPD_NUM,   b_sel: OPD_INVM, alu_op: ALU_MOV, src: SRC_U,
        dst: DST_F,   nxt: NX_NEXT},
      '{a_sel: OPD_GAIN,  b_sel: OPD_V,    alu_op: ALU_ADD, src: SRC_Z,
        dst: DST_D,   nxt: NX_NEXT},
      '{a_sel: OPD_GAIN,  b_sel: OPD_D,    alu_op: ALU_NEG, src: SRC_U,
        dst: DST_NEG, nxt: NX_NEXT},
      '{a_sel: OPD_GAIN,  b_sel: OPD_F,    alu_op: ALU_SUB, src: SRC_NEG,
        dst: DST_DZ,  nxt: NX_DONE_IF_DT0},
      '{a_sel: OPD_DZ,    b_sel: OPD_DT,   alu_op: ALU_ADD, src: SRC_Z,
        dst: DST_Z,   nxt: NX_DONE}
   };

endpackage

// ===== sv/ndo_mul.sv =====
// ----------------------------------------------------------------------------
// ndo_mul
// Shared fixed-point multiplier: sign-magnitude, low and high partial products
// accumulated in turn, then truncating shift and saturation.
// ----------------------------------------------------------------------------
module ndo_mul #(
   parameter int DW = 32,
   parameter int FB = 16
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic                 lo,
   input  logic                 hi,
   input  logic                 post,
   input  logic signed [DW-1:0] op_a,
   input  logic signed [DW-1:0] op_b,
   output logic signed [DW-1:0] prod,
   output logic                 ovf
);

   localparam int HW = (DW + 1) / 2;
   localparam int PW = 2 * DW;
   localparam int MW = HW + DW;
   localparam logic [PW-1:0] LIM = PW'(1) << (DW - 1);

   logic [DW-1:0] mag_a_ff, mag_a_in;
   logic [DW-1:0] mag_b_ff, mag_b_in;
   logic          neg_ff;
   logic [PW-1:0] acc_ff, acc_in;
   logic signed [DW-1:0] prod_ff, prod_in;
   logic          ovf_ff, ovf_in;

   logic [HW-1:0] half;
   logic [MW-1:0] pp;
   logic [PW-1:0] q;

   assign mag_a_in = op_a[DW-1] ? DW'(-op_a) : DW'(op_a);
   assign mag_b_in = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);

   assign half = lo ? mag_a_ff[HW-1:0] : HW'(mag_a_ff[DW-1:HW]);
   assign pp   = MW'(half) * MW'(mag_b_ff);
   assign acc_in = lo ? PW'(pp) : acc_ff + (PW'(pp) << HW);

   assign q = acc_ff >> FB;

   always_comb begin
      if (neg_ff) begin
         if (q > LIM) begin
            prod_in = LIM[DW-1:0];
            ovf_in  = 1'b1;
         end else begin
            prod_in = DW'(0) - q[DW-1:0];
            ovf_in  = 1'b0;
         end
      end else begin
         if (q > LIM - PW'(1)) begin
            prod_in = DW'(LIM - PW'(1));
            ovf_in  = 1'b1;
         end else begin
            prod_in = q[DW-1:0];
            ovf_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         neg_ff   <= op_a[DW-1] ^ op_b[DW-1];
      end
      if (lo || hi) begin
         acc_ff <= acc_in;
      end
      if (post) begin
         prod_ff <= prod_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign prod = prod_ff;
   assign ovf  = ovf_ff;

endmodule

// ===== sv/ndo_dpath.sv =====
// ----------------------------------------------------------------------------
// ndo_dpath
// Observer datapath: operand registers, operand select, shared multiplier,
// saturating add/subtract unit and the observer state.
// ----------------------------------------------------------------------------
module ndo_dpath #(
   parameter int DW = 32,
   parameter int FB = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  ndo_pkg::ctl_type    ctl,
   input  ndo_pkg::cfg_type    cfg,
   input  logic signed [31:0]  position,
   input  logic signed [31:0]  velocity,
   input  logic signed [31:0]  control_input,
   output logic signed [31:0]  dout,
   output logic                res_flag,
   output logic                dt_zero
);

   import ndo_pkg::*;

   localparam int SW = (DW > 32 ? DW : 32) + 2;
   localparam logic signed [SW-1:0] S_MAX = (SW'(1) << (DW - 1)) - SW'(1);
   localparam logic signed [SW-1:0] S_MIN = ~S_MAX;
   localparam logic signed [SW-1:0] O_MAX = (SW'(1) << 31) - SW'(1);
   localparam logic signed [SW-1:0] O_MIN = ~O_MAX;

   function automatic logic ovf_dw(input logic signed [SW-1:0] v);
      return (v > S_MAX) || (v < S_MIN);
   endfunction

   function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
      logic signed [DW-1:0] r;
      if (v > S_MAX) r = S_MAX[DW-1:0];
      else if (v < S_MIN) r = S_MIN[DW-1:0];
      else r = v[DW-1:0];
      return r;
   endfunction

   logic signed [SW-1:0] x_w, v_w, u_w, gain_w, invm_w, damp_w, stiff_w, fric_w, dt_w;
   logic                 in_ovf;

   logic signed [DW-1:0] x_ff, v_ff, u_ff;
   logic signed [DW-1:0] w_ff, num_ff, f_ff, d_ff, dz_ff, z_ff;
   logic signed [SW-1:0] neg_ff;
   logic                 flag_ff, flag_in;

   logic signed [DW-1:0] op_a, op_b, prod;
   logic                 mul_ovf;

   logic signed [SW-1:0] t_w, src_w, r_w, d_w;
   logic signed [DW-1:0] r_sat;
   logic                 alu_ovf, out_ovf;

   assign x_w     = SW'(position);
   assign v_w     = SW'(velocity);
   assign u_w     = SW'(control_input);
   assign gain_w  = SW'(cfg.observer_gain);
   assign invm_w  = SW'(cfg.inverse_mass);
   assign damp_w  = SW'(cfg.damping);
   assign stiff_w = SW'(cfg.stiffness);
   assign fric_w  = SW'(cfg.friction_coeff);
   assign dt_w    = SW'(cfg.time_step);

   assign in_ovf = ovf_dw(x_w) | ovf_dw(v_w) | ovf_dw(u_w) | ovf_dw(gain_w)
                 | ovf_dw(invm_w) | ovf_dw(damp_w) | ovf_dw(stiff_w)
                 | ovf_dw(fric_w) | ovf_dw(dt_w);

   assign dt_zero = (cfg.time_step == '0);

   function automatic logic signed [DW-1:0] opnd(input opnd_type sel);
      logic signed [DW-1:0] r;
      unique case (sel)
         OPD_X:     r = x_ff;
         OPD_V:     r = v_ff;
         OPD_U:     r = u_ff;
         OPD_GAIN:  r = sat_dw(gain_w);
         OPD_INVM:  r = sat_dw(invm_w);
         OPD_DAMP:  r = sat_dw(damp_w);
         OPD_STIFF: r = sat_dw(stiff_w);
         OPD_FRIC:  r = sat_dw(fric_w);
         OPD_DT:    r = sat_dw(dt_w);
         OPD_W:     r = w_ff;
         OPD_NUM:   r = num_ff;
         OPD_F:     r = f_ff;
         OPD_D:     r = d_ff;
         OPD_DZ:    r = dz_ff;
         default:   r = '0;
      endcase
      return r;
   endfunction

   always_comb begin
      op_a = opnd(ctl.a_sel);
      op_b = opnd(ctl.b_sel);
   end

   ndo_mul #(
      .DW (DW),
      .FB (FB)
   ) u_mul (
      .clock (clock),
      .load  (ctl.load),
      .lo    (ctl.lo),
      .hi    (ctl.hi),
      .post  (ctl.post),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod),
      .ovf   (mul_ovf)
   );

   assign t_w = SW'(prod);

   always_comb begin
      unique case (ctl.src)
         SRC_U:   src_w = SW'(u_ff);
         SRC_NUM: src_w = SW'(num_ff);
         SRC_Z:   src_w = SW'(z_ff);
         SRC_NEG: src_w = neg_ff;
         default: src_w = '0;
      endcase
   end

   always_comb begin
      unique case (ctl.alu_op)
         ALU_MOV: r_w = t_w;
         ALU_ADD: r_w = src_w + t_w;
         ALU_SUB: r_w = src_w - t_w;
         ALU_NEG: r_w = -t_w;
         default: r_w = t_w;
      endcase
   end

   assign r_sat   = sat_dw(r_w);
   assign alu_ovf = ((ctl.alu_op == ALU_ADD) || (ctl.alu_op == ALU_SUB)) && ovf_dw(r_w);

   always_comb begin
      flag_in = flag_ff;
      if (ctl.start) begin
         flag_in = in_ovf;
      end else if (ctl.alu) begin
         flag_in = flag_ff | mul_ovf | alu_ovf;
      end
   end

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
      if (ctl.start) begin
         x_ff <= sat_dw(x_w);
         v_ff <= sat_dw(v_w);
         u_ff <= sat_dw(u_w);
      end
      if (ctl.alu) begin
         unique case (ctl.dst)
            DST_W:   w_ff   <= r_sat;
            DST_NUM: num_ff <= r_sat;
            DST_F:   f_ff   <= r_sat;
            DST_D:   d_ff   <= r_sat;
            DST_DZ:  dz_ff  <= r_sat;
            DST_NEG: neg_ff <= r_w;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_ff <= '0;
      end else if (ctl.alu && (ctl.dst == DST_Z)) begin
         z_ff <= r_sat;
      end
   end

   // result is clamped to the 32-bit port
   assign d_w     = SW'(d_ff);
   assign out_ovf = (d_w > O_MAX) || (d_w < O_MIN);
   assign dout    = (d_w > O_MAX) ? O_MAX[31:0] :
                    (d_w < O_MIN) ? O_MIN[31:0] : d_w[31:0];
   assign res_flag = flag_ff | out_ovf;

endmodule

// ===== sv/ndo_seq.sv =====
// ----------------------------------------------------------------------------
// ndo_seq
// Microcode sequencer: step counter into the control store, five phases per
// step (load, low product, high product, saturate, combine), early exit.
// ----------------------------------------------------------------------------
module ndo_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             dt_zero,
   input  logic             out_free,
   output ndo_pkg::ctl_type ctl,
   output logic             idle,
   output logic             done
);

   import ndo_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         word;

   assign word = UCODE[step_ff];
   assign idle = (phase_ff == PH_IDLE);

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      done     = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               step_in  = '0;
               phase_in = PH_LOAD;
            end
         end
         PH_LOAD: phase_in = PH_LO;
         PH_LO:   phase_in = PH_HI;
         PH_HI:   phase_in = PH_POST;
         PH_POST: phase_in = PH_ALU;
         PH_ALU: begin
            unique case (word.nxt)
               NX_NEXT: begin
                  step_in  = step_ff + STEP_W'(1);
                  phase_in = PH_LOAD;
               end
               NX_DONE: phase_in = PH_DONE;
               NX_DONE_IF_DT0: begin
                  if (dt_zero) begin
                     phase_in = PH_DONE;
                  end else begin
                     step_in  = step_ff + STEP_W'(1);
                     phase_in = PH_LOAD;
                  end
               end
               default: phase_in = PH_DONE;
            endcase
         end
         PH_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   assign ctl.start  = idle && start;
   assign ctl.load   = (phase_ff == PH_LOAD);
   assign ctl.lo     = (phase_ff == PH_LO);
   assign ctl.hi     = (phase_ff == PH_HI);
   assign ctl.post   = (phase_ff == PH_POST);
   assign ctl.alu    = (phase_ff == PH_ALU);
   assign ctl.a_sel  = word.a_sel;
   assign ctl.b_sel  = word.b_sel;
   assign ctl.alu_op = word.alu_op;
   assign ctl.src    = word.src;
   assign ctl.dst    = word.dst;

endmodule

// ===== sv/nonlinear_disturbance_observer.sv =====
// ----------------------------------------------------------------------------
// nonlinear_disturbance_observer
// Requests are taken only while idle: the 10 microcode steps run on the one
//   shared multiplier (ending after the dz step when dt is 0) before the next.
// A result waiting in the output register does not block the next request;
//   the next result is held until that register is free.
// Reset: config registers return to defaults, observer state clears to 0.
// ----------------------------------------------------------------------------
module nonlinear_disturbance_observer #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [31:0]               req_position,
   input  logic signed [31:0]               req_velocity,
   input  logic signed [31:0]               req_control_input,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [31:0]               rsp_disturbance_estimate,
   output logic                             rsp_saturated,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ndo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_data
);

   import ndo_pkg::*;

   cfg_type            cfg_ff;
   ctl_type            ctl;
   logic               idle, done, dt_zero, out_free;
   logic signed [31:0] dout;
   logic               res_flag;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_data_ff;
   logic               rsp_sat_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN:     cfg_ff.observer_gain  <= csr_data[30:0];
            CSR_INV_MASS: cfg_ff.inverse_mass   <= csr_data[30:0];
            CSR_DAMPING:  cfg_ff.damping        <= $signed(csr_data);
            CSR_STIFF:    cfg_ff.stiffness      <= $signed(csr_data);
            CSR_FRICTION: cfg_ff.friction_coeff <= $signed(csr_data);
            CSR_TIME:     cfg_ff.time_step      <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   assign req_ready = idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   ndo_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid),
      .dt_zero  (dt_zero),
      .out_free (out_free),
      .ctl      (ctl),
      .idle     (idle),
      .done     (done)
   );

   ndo_dpath #(
      .DW (DATA_WIDTH),
      .FB (FRAC_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .cfg           (cfg_ff),
      .position      (req_position),
      .velocity      (req_velocity),
      .control_input (req_control_input),
      .dout          (dout),
      .res_flag      (res_flag),
      .dt_zero       (dt_zero)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= dout;
         rsp_sat_ff  <= res_flag;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_disturbance_estimate = rsp_data_ff;
   assign rsp_saturated            = rsp_sat_ff;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nonlinear disturbance observer. Sample requests
// come from a queue and go through a valid/ready driver. A monitor predicts
// each disturbance estimate and saturation flag with a fixed-point model of
// the observer and compares every response in order. Register settings change
// between drained batches. The batches cover reset defaults, the extremes,
// zero inverse mass, zero and oversized time steps, and unmapped indexes.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ndo_pkg::*;

   localparam int     FRAC          = 16;
   localparam longint SAT_MAX       = 64'sd2147483647;
   localparam longint SAT_MIN       = -64'sd2147483648;
   localparam int     SETTLE_CYCLES = 60;
   localparam int     STALL_CYCLES  = 600;
   localparam int     BATCH         = 155;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] control_input;
   } sample_type;

   typedef struct packed {
      logic signed [31:0] estimate;
      logic               saturated;
   } estimate_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [31:0]   req_position = '0;
   logic signed [31:0]   req_velocity = '0;
   logic signed [31:0]   req_control_input = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [31:0]   rsp_disturbance_estimate;
   logic                 rsp_saturated;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GAIN;
   logic [31:0]          csr_data = '0;

   sample_type   sample_q[$];
   estimate_type pending_estimates[$];

   cfg_type model_cfg = CFG_RESET;
   longint  obs_state = 0;
   logic    sat_seen;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int req_accepts = 0;
   int req_handled = 0;
   int error_count = 0;
   int stalls_requested = 0;
   int stalls_served = 0;
   int stall_left = 0;

   nonlinear_disturbance_observer dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_position             (req_position),
      .req_velocity             (req_velocity),
      .req_control_input        (req_control_input),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_disturbance_estimate (rsp_disturbance_estimate),
      .rsp_saturated            (rsp_saturated),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("tb: errors");
      $finish;
   end

   // ---- observer prediction ----

   function automatic longint clamp32(longint v);
      if (v > SAT_MAX) begin
         sat_seen = 1'b1;
         return SAT_MAX;
      end
      if (v < SAT_MIN) begin
         sat_seen = 1'b1;
         return SAT_MIN;
      end
      return v;
   endfunction

   // exact product, truncated toward zero, then clamped
   function automatic longint fx_mul(longint a, longint b);
      logic [63:0] ma, mb, q;
      logic        neg;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      q   = (ma * mb) >> FRAC;
      if (neg) begin
         if (q > 64'd2147483648) begin
            sat_seen = 1'b1;
            return SAT_MIN;
         end
         return -longint'(q);
      end
      if (q > 64'd2147483647) begin
         sat_seen = 1'b1;
         return SAT_MAX;
      end
      return longint'(q);
   endfunction

   function automatic estimate_type observe_step(sample_type s);
      longint       x, v, u, gain, invm, c, k, b, dt, v3, num, f, d, dz;
      estimate_type r;
      sat_seen = 1'b0;
      x    = longint'(s.position);
      v    = longint'(s.velocity);
      u    = longint'(s.control_input);
      gain = longint'({33'd0, model_cfg.observer_gain});
      invm = longint'({33'd0, model_cfg.inverse_mass});
      c    = longint'($signed(model_cfg.damping));
      k    = longint'($signed(model_cfg.stiffness));
      b    = longint'($signed(model_cfg.friction_coeff));
      dt   = longint'({47'd0, model_cfg.time_step});
      v3   = fx_mul(fx_mul(v, v), v);
      num  = clamp32(u - fx_mul(c, v));
      num  = clamp32(num - fx_mul(k, x));
      num  = clamp32(num - fx_mul(b, v3));
      f    = fx_mul(num, invm);
      d    = clamp32(obs_state + fx_mul(gain, v));
      dz   = clamp32(-fx_mul(gain, d) - fx_mul(gain, f));
      obs_state   = clamp32(obs_state + fx_mul(dz, dt));
      r.estimate  = d[31:0];
      r.saturated = sat_seen;
      return r;
   endfunction

   // ---- stimulus helpers ----

   function automatic logic [31:0] small_signed(int lim);
      logic [31:0] r;
      r = $urandom_range(0, lim);
      return $urandom_range(1) ? -r : r;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(7))
         0, 1:    return $urandom();
         2, 3, 4: return small_signed(1 << 18);
         5:       return small_signed(1 << 24);
         default: begin
            case ($urandom_range(4))
               0:       return '0;
               1:       return 32'd1;
               2:       return '1;
               3:       return 32'h7FFF_FFFF;
               default: return 32'h8000_0000;
            endcase
         end
      endcase
   endfunction

   function automatic cfg_type random_cfg(bit wild);
      cfg_type     c;
      logic [31:0] g, m, t;
      g = wild ? rand_word() : $urandom_range(0, 100 << 16);
      m = wild ? rand_word() : $urandom_range(0, 4 << 16);
      t = (wild && $urandom_range(1)) ? $urandom_range(0, 131071) : $urandom_range(0, 1024);
      c.observer_gain  = g[30:0];
      c.inverse_mass   = m[30:0];
      c.damping        = wild ? rand_word() : small_signed(20 << 16);
      c.stiffness      = wild ? rand_word() : small_signed(50 << 16);
      c.friction_coeff = wild ? rand_word() : small_signed(1 << 16);
      c.time_step      = t[16:0];
      return c;
   endfunction

   task automatic add_sample(logic [31:0] x, logic [31:0] v, logic [31:0] u);
      sample_type s;
      s.position      = x;
      s.velocity      = v;
      s.control_input = u;
      sample_q.push_back(s);
   endtask

   task automatic queue_random(int n);
      repeat (n) add_sample(rand_word(), rand_word(), rand_word());
   endtask

   task automatic wait_drained();
      while (sample_q.size() != 0 || req_valid || pending_estimates.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_cfg(cfg_type c);
      write_reg(CSR_GAIN, {1'b0, c.observer_gain});
      write_reg(CSR_INV_MASS, {1'b0, c.inverse_mass});
      write_reg(CSR_DAMPING, c.damping);
      write_reg(CSR_STIFF, c.stiffness);
      write_reg(CSR_FRICTION, c.friction_coeff);
      write_reg(CSR_TIME, {15'd0, c.time_step});
   endtask

   // ---- request driver ----

   always @(negedge clock) begin : drive_requests
      sample_type s;
      logic       offer;
      offer = req_valid;
      if (req_valid && req_accepts != req_handled) begin
         req_handled++;
         offer = 1'b0;
      end
      if (!offer && sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         s = sample_q.pop_front();
         req_position      <= s.position;
         req_velocity      <= s.velocity;
         req_control_input <= s.control_input;
         offer = 1'b1;
      end
      req_valid <= offer;
   end

   // ---- response receiver ----

   always @(negedge clock) begin : drive_rsp_ready
      if (stalls_requested != stalls_served) begin
         stalls_served++;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---- monitor and scoreboard ----

   always @(posedge clock) begin : watch_ports
      sample_type   s;
      estimate_type want;
      if (reset) begin
         model_cfg = CFG_RESET;
         obs_state = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN:     model_cfg.observer_gain  = csr_data[30:0];
               CSR_INV_MASS: model_cfg.inverse_mass   = csr_data[30:0];
               CSR_DAMPING:  model_cfg.damping        = csr_data;
               CSR_STIFF:    model_cfg.stiffness      = csr_data;
               CSR_FRICTION: model_cfg.friction_coeff = csr_data;
               CSR_TIME:     model_cfg.time_step      = csr_data[16:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            s.position      = req_position;
            s.velocity      = req_velocity;
            s.control_input = req_control_input;
            pending_estimates.push_back(observe_step(s));
            req_accepts++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_estimates.size() == 0) begin
               if (error_count < 10)
                  $display("%0t unexpected response: estimate %h saturated %b",
                           $time, rsp_disturbance_estimate, rsp_saturated);
               error_count++;
            end else begin
               want = pending_estimates.pop_front();
               if (rsp_disturbance_estimate !== want.estimate ||
                   rsp_saturated !== want.saturated) begin
                  if (error_count < 10)
                     $display("%0t mismatch: estimate exp %h got %h, saturated exp %b got %b",
                              $time, want.estimate, rsp_disturbance_estimate,
                              want.saturated, rsp_saturated);
                  error_count++;
               end
            end
         end
      end
   end

   // ---- test sequence ----

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 9;
      recv_idle_pct = 77;

      // directed requests on reset defaults
      add_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      add_sample(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      add_sample(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
      add_sample(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
      add_sample(32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
      add_sample(32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
      add_sample(32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000);
      add_sample(32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
      add_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      add_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      add_sample(32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
      add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_sample(32'hFFFE_0000, 32'h0001_8000, 32'h000A_0000);
      add_sample(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_sample(32'h0003_0000, 32'hFFFD_0000, 32'hFFEC_0000);
      wait_drained();

      write_cfg(random_cfg(1'b0));
      queue_random(BATCH);
      wait_drained();

      // max gain via upper-bit masking, zero inverse mass, zero time step
      write_reg(CSR_GAIN, 32'hFFFF_FFFF);
      write_reg(CSR_INV_MASS, 32'h0000_0000);
      write_reg(CSR_DAMPING, 32'h8000_0000);
      write_reg(CSR_STIFF, 32'h7FFF_FFFF);
      write_reg(CSR_FRICTION, 32'h8000_0000);
      write_reg(CSR_TIME, 32'h0000_0000);
      queue_random(BATCH);
      stalls_requested++;
      wait_drained();

      send_idle_pct = 77;
      recv_idle_pct = 9;

      // zero gain, max inverse mass, largest time step
      write_reg(CSR_GAIN, 32'h0000_0000);
      write_reg(CSR_INV_MASS, 32'hFFFF_FFFF);
      write_reg(CSR_DAMPING, 32'h7FFF_FFFF);
      write_reg(CSR_STIFF, 32'h8000_0000);
      write_reg(CSR_FRICTION, 32'h7FFF_FFFF);
      write_reg(CSR_TIME, 32'hFFFF_FFFF);
      queue_random(BATCH);
      wait_drained();

      write_cfg(random_cfg(1'b1));
      queue_random(BATCH);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;

      write_cfg(random_cfg(1'b1));
      queue_random(BATCH);
      wait_drained();

      // unmapped indexes must leave the registers alone
      write_cfg(CFG_RESET);
      write_reg(CSR_SPARE_LO, $urandom());
      write_reg(CSR_SPARE_HI, $urandom());
      queue_random(BATCH);
      wait_drained();

      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
